// ===== rtl/qbe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the quadratic basis expansion block.
// Depends on nothing; every other file of the block but qbe_job_fifo imports it.
package qbe_pkg;

  localparam int COORD_W = 32;  // Q16.16 coordinate
  localparam int VALUE_W = 48;  // Q32.16 matrix entry
  localparam int INDEX_W = 6;   // column position within a row
  localparam int CFG_W   = 4;   // active_dim register

  localparam logic [CFG_W-1:0]   ACTIVE_DIM_RST = 4'd8;
  localparam logic [VALUE_W-1:0] ONE_Q16        = 48'h0000_0001_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_value;
  } coord_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] term_value;
    logic [INDEX_W-1:0]        term_index;
    logic                      row_end;
  } term_item_t;

endpackage

// ===== rtl/qbe_coord_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one coordinate per transaction.
// Depends on qbe_pkg for the payload type.
interface qbe_coord_if;
  import qbe_pkg::*;

  logic        valid;
  logic        ready;
  coord_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/qbe_term_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one model matrix entry per transaction.
// Depends on qbe_pkg for the payload type.
interface qbe_term_if;
  import qbe_pkg::*;

  logic       valid;
  logic       ready;
  term_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/qbe_front.sv =====
`timescale 1ns / 1ps
// Front end: holds active_dim, collects the coordinates of a point and
// hands a complete point to the job queue. Depends on qbe_pkg, qbe_coord_if.
module qbe_front #(
  parameter int MAX_DIM = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [qbe_pkg::CFG_W-1:0] cfg_data_i,
  qbe_coord_if.sink                coord_if,
  output logic                     job_valid_o,
  input  logic                     job_ready_i,
  output logic [MAX_DIM*qbe_pkg::COORD_W+$clog2(MAX_DIM+1)-1:0] job_data_o
);
  import qbe_pkg::*;

  localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0]   active_dim_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COORD_W-1:0] store_q [MAX_DIM];
  logic [DIM_W-1:0]   eff_dim;
  logic               last;
  logic               accept;
  logic [MAX_DIM-1:0][COORD_W-1:0] job_coords;

  // Out-of-range settings: zero acts as one, anything above MAX_DIM as MAX_DIM.
  always_comb begin
    if (active_dim_q == '0) begin
      eff_dim = DIM_W'(1);
    end else if (int'(active_dim_q) > MAX_DIM) begin
      eff_dim = DIM_W'(MAX_DIM);
    end else begin
      eff_dim = DIM_W'(active_dim_q);
    end
  end

  // Also covers a dimension lowered mid-point: the next coordinate completes it.
  assign last   = (DIM_W'(cnt_q) + DIM_W'(1)) >= eff_dim;
  assign coord_if.ready = !last || job_ready_i;
  assign accept = coord_if.valid && coord_if.ready;
  assign job_valid_o = coord_if.valid && last;

  always_comb begin
    for (int m = 0; m < MAX_DIM; m++) begin
      job_coords[m] = (CNT_W'(m) == cnt_q) ? coord_if.data.coord_value : store_q[m];
    end
  end

  assign job_data_o = {eff_dim, job_coords};
  assign cnt_d = last ? '0 : cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_dim_q <= ACTIVE_DIM_RST;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        active_dim_q <= cfg_data_i;
      end
      if (accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[cnt_q] <= coord_if.data.coord_value;
    end
  end

endmodule

// ===== rtl/qbe_job_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue of complete points between the front and back ends.
// Depends on nothing but its width parameter.
module qbe_job_fifo #(
  parameter int WIDTH = 260
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/qbe_back.sv =====
`timescale 1ns / 1ps
// Back end: walks one point through quadratic, linear and constant terms,
// one entry per cycle while term_if is ready, through a registered multiplier and
// an output register. Depends on qbe_pkg and qbe_term_if.
module qbe_back #(
  parameter int MAX_DIM = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  logic [MAX_DIM*qbe_pkg::COORD_W+$clog2(MAX_DIM+1)-1:0] job_data_i,
  qbe_term_if.source term_if
);
  import qbe_pkg::*;

  localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUAD,
    ST_LIN,
    ST_CONST
  } state_e;

  typedef enum logic [1:0] {
    K_DIAG,
    K_OFF,
    K_PASS
  } kind_e;

  state_e           state_q;
  logic [DIM_W-1:0] dim_q;
  logic [CNT_W-1:0] i_q, j_q, li_q;
  logic [INDEX_W-1:0] k_q;
  logic [COORD_W-1:0] row_q [MAX_DIM];
  logic [COORD_W-1:0] col_q [MAX_DIM];
  logic [COORD_W-1:0] lin_q [MAX_DIM];

  logic               s1_valid_q;
  logic signed [63:0] s1_prod_q;
  kind_e              s1_kind_q;
  logic [INDEX_W-1:0] s1_idx_q;
  logic               s1_end_q;

  logic       out_valid_q;
  term_item_t out_q;

  logic [MAX_DIM-1:0][COORD_W-1:0] job_coords;
  logic [DIM_W-1:0]   job_dim;
  logic               adv;
  logic               issue;
  logic               j_last, i_last, li_last;
  logic signed [63:0] mult;
  logic signed [63:0] s1_prod_d;
  kind_e              s1_kind_d;
  logic [VALUE_W-1:0] term_d;

  assign {job_dim, job_coords} = job_data_i;
  assign job_ready_o = (state_q == ST_IDLE);

  // The whole pipe moves together whenever the output register can take a value.
  assign adv   = !out_valid_q || term_if.ready;
  assign issue = adv && (state_q != ST_IDLE);

  assign j_last  = (DIM_W'(j_q)  + DIM_W'(1)) == dim_q;
  assign i_last  = (DIM_W'(i_q)  + DIM_W'(1)) == dim_q;
  assign li_last = (DIM_W'(li_q) + DIM_W'(1)) == dim_q;

  assign mult = $signed(row_q[0]) * $signed(col_q[0]);

  always_comb begin
    s1_prod_d = mult;
    s1_kind_d = (j_q == i_q) ? K_DIAG : K_OFF;
    case (state_q)
      ST_LIN: begin
        s1_prod_d = 64'($signed(lin_q[0]));
        s1_kind_d = K_PASS;
      end
      ST_CONST: begin
        s1_prod_d = 64'(ONE_Q16);
        s1_kind_d = K_PASS;
      end
      default: begin
      end
    endcase
  end

  // Dropping low bits of the exact product floors it; the diagonal drops one more.
  always_comb begin
    case (s1_kind_q)
      K_DIAG:  term_d = {s1_prod_q[63], s1_prod_q[63:17]};
      K_OFF:   term_d = s1_prod_q[63:16];
      default: term_d = s1_prod_q[VALUE_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dim_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      li_q        <= '0;
      k_q         <= '0;
    end else begin
      if (adv) begin
        s1_valid_q  <= issue;
        out_valid_q <= s1_valid_q;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            dim_q   <= job_dim;
            i_q     <= '0;
            j_q     <= '0;
            li_q    <= '0;
            k_q     <= '0;
            state_q <= ST_QUAD;
          end
        end
        ST_QUAD: begin
          if (issue) begin
            k_q <= k_q + INDEX_W'(1);
            if (j_last) begin
              if (i_last) begin
                state_q <= ST_LIN;
              end else begin
                i_q <= i_q + CNT_W'(1);
                j_q <= i_q + CNT_W'(1);
              end
            end else begin
              j_q <= j_q + CNT_W'(1);
            end
          end
        end
        ST_LIN: begin
          if (issue) begin
            k_q  <= k_q + INDEX_W'(1);
            li_q <= li_q + CNT_W'(1);
            if (li_last) begin
              state_q <= ST_CONST;
            end
          end
        end
        ST_CONST: begin
          if (issue) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Operand shift lines: row_q[0] is x_i, col_q[0] is x_j, lin_q[0] the next linear term.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i) begin
      for (int m = 0; m < MAX_DIM; m++) begin
        row_q[m] <= job_coords[m];
        col_q[m] <= job_coords[m];
        lin_q[m] <= job_coords[m];
      end
    end else if (issue && state_q == ST_QUAD) begin
      if (j_last) begin
        for (int m = 0; m < MAX_DIM - 1; m++) begin
          row_q[m] <= row_q[m+1];
          col_q[m] <= row_q[m+1];
        end
      end else begin
        for (int m = 0; m < MAX_DIM - 1; m++) begin
          col_q[m] <= col_q[m+1];
        end
      end
    end else if (issue && state_q == ST_LIN) begin
      for (int m = 0; m < MAX_DIM - 1; m++) begin
        lin_q[m] <= lin_q[m+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_prod_q <= s1_prod_d;
      s1_kind_q <= s1_kind_d;
      s1_idx_q  <= k_q;
      s1_end_q  <= (state_q == ST_CONST);
    end
    if (adv && s1_valid_q) begin
      out_q.term_value <= term_d;
      out_q.term_index <= s1_idx_q;
      out_q.row_end    <= s1_end_q;
    end
  end

  assign term_if.valid = out_valid_q;
  assign term_if.data  = out_q;

endmodule

// ===== rtl/quadratic_basis_expansion.sv =====
`timescale 1ns / 1ps
// Top level of the quadratic basis expansion block: front end, job queue, back end.
// Depends on qbe_pkg, qbe_coord_if, qbe_term_if, qbe_front, qbe_job_fifo, qbe_back.
//
//   channel    dir   per transaction
//   coord_if   in    one Q16.16 coordinate of the current point
//   term_if    out   one Q32.16 matrix entry with column index and row-end flag
//   cfg_we_i   in    write of active_dim from cfg_data_i
//
// The back end emits one entry per cycle while term_if is ready, through a registered
// 32x32 multiplier and an output register, and it loads each point from the queue
// in its idle state before it emits the entries of that point.
// The front end takes one coordinate per cycle; a point is queued in a
// two-entry job queue, and the front end stalls only when that queue is full.
// Reset restores active_dim to 8 and empties the point counter and queue.
module quadratic_basis_expansion #(
  parameter int MAX_DIM = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [qbe_pkg::CFG_W-1:0] cfg_data_i,
  qbe_coord_if.sink                 coord_if,
  qbe_term_if.source                term_if
);
  import qbe_pkg::*;

  localparam int JOB_W = MAX_DIM * COORD_W + $clog2(MAX_DIM + 1);

  logic             push_valid;
  logic             push_ready;
  logic [JOB_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [JOB_W-1:0] pop_data;

  qbe_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .coord_if   (coord_if),
    .job_valid_o(push_valid),
    .job_ready_i(push_ready),
    .job_data_o (push_data)
  );

  qbe_job_fifo #(
    .WIDTH(JOB_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  qbe_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .job_data_i (pop_data),
    .term_if    (term_if)
  );

endmodule

// ===== verif/tb_quadratic_basis_expansion.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_basis_expansion: streams coordinates, predicts every
// model matrix row locally and compares each entry as it leaves the block.
// Depends on qbe_pkg, qbe_coord_if, qbe_term_if and the block's RTL.
module tb_quadratic_basis_expansion;
  import qbe_pkg::*;

  localparam int DIM_LIMIT   = 8;
  localparam int BP_DIM      = 4;     // dimension used while the receiver holds off
  localparam int SETTLE      = 48;    // cycles allowed after the last entry of a row
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int STALL_LIMIT = 3000;  // cycles without any transaction
  localparam int MAX_PRINTS  = 40;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_data_i;

  qbe_coord_if coord_ch ();
  qbe_term_if  term_ch ();

  quadratic_basis_expansion #(
    .MAX_DIM(DIM_LIMIT)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .coord_if  (coord_ch),
    .term_if   (term_ch)
  );

  // Local copy of the block's state.
  logic [CFG_W-1:0]   dim_reg;
  logic [COORD_W-1:0] point_store [DIM_LIMIT];
  int unsigned        point_fill;
  term_item_t         expected_terms [$];

  int unsigned err_count      = 0;
  int unsigned coords_sent    = 0;
  int unsigned rows_predicted = 0;
  int unsigned terms_checked  = 0;
  int unsigned dim_writes     = 0;
  int unsigned idle_cycles    = 0;
  bit          no_gaps        = 1'b0;
  bit          hold_req       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned effective_dim(input logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  // Queues the entries of one row built from the first d stored coordinates.
  function automatic void push_row(input int unsigned d);
    logic signed [63:0] xi;
    logic signed [63:0] xj;
    logic signed [63:0] prod;
    term_item_t         t;
    int unsigned        col;
    col = 0;
    for (int i = 0; i < d; i++) begin
      xi = {{32{point_store[i][COORD_W-1]}}, point_store[i]};
      for (int j = i; j < d; j++) begin
        xj   = {{32{point_store[j][COORD_W-1]}}, point_store[j]};
        // Arithmetic shifts floor the result; the diagonal loses one more bit for the half.
        prod = (i == j) ? ((xi * xj) >>> 17) : ((xi * xj) >>> 16);
        t.term_value = prod[VALUE_W-1:0];
        t.term_index = col[INDEX_W-1:0];
        t.row_end    = 1'b0;
        expected_terms.push_back(t);
        col++;
      end
    end
    for (int i = 0; i < d; i++) begin
      t.term_value = {{(VALUE_W-COORD_W){point_store[i][COORD_W-1]}}, point_store[i]};
      t.term_index = col[INDEX_W-1:0];
      t.row_end    = 1'b0;
      expected_terms.push_back(t);
      col++;
    end
    t.term_value = ONE_Q16;
    t.term_index = col[INDEX_W-1:0];
    t.row_end    = 1'b1;
    expected_terms.push_back(t);
    rows_predicted++;
  endfunction

  function automatic void predict_coord(input logic [COORD_W-1:0] v);
    int unsigned d;
    d = effective_dim(dim_reg);
    if (point_fill < DIM_LIMIT) point_store[point_fill] = v;
    point_fill++;
    // A point that already holds enough coordinates after the dimension was lowered
    // is completed by this one and uses only its leading coordinates.
    if (point_fill >= d) begin
      point_fill = 0;
      push_row(d);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (r < 4) return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned col,
                                 input logic [63:0] got, input logic [63:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] mismatch in %s at column %0d: got 0x%0h, expected 0x%0h",
               $realtime, field, col, got, want);
  endtask

  // Offers one coordinate and returns at the rising edge of its transaction, valid still high.
  task automatic send_coord(input logic [COORD_W-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      coord_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    coord_ch.valid            <= 1'b1;
    coord_ch.data.coord_value <= v;
    @(posedge clk_i);
    while (!coord_ch.ready) @(posedge clk_i);
    predict_coord(v);
    coords_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    coord_ch.valid <= 1'b0;
    while (expected_terms.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_dim(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    dim_reg = v;
    dim_writes++;
  endtask

  // Full-width point at the reset dimension with the extremes of the coordinate range.
  task automatic test_corner_point();
    logic [COORD_W-1:0] corners [8];
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_8001};
    foreach (corners[k]) send_coord(corners[k]);
  endtask

  // One-coordinate points, including a dimension of zero which behaves as one.
  task automatic test_dim_bounds();
    write_dim(4'd1);
    send_coord(32'h8000_0000);
    send_coord(32'h7FFF_FFFF);
    send_coord(32'hFFFF_FFFF);
    write_dim(4'd0);
    send_coord(random_coord());
    send_coord(random_coord());
  endtask

  task automatic test_midpoint_dim_change();
    write_dim(4'd4);
    repeat (3) send_coord(random_coord());
    write_dim(4'd2);
    send_coord(random_coord());
    send_coord(random_coord());
    write_dim(4'd5);
    repeat (4) send_coord(random_coord());
  endtask

  // The receiver holds off while full points keep coming, so the job queue fills
  // and the input stalls; afterwards the sender waits for every entry to arrive.
  task automatic test_backpressure();
    write_dim(CFG_W'(BP_DIM));
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    repeat (4 * BP_DIM) send_coord(random_coord());
    no_gaps = 1'b0;
    drain_results();
  endtask

  task automatic test_random_points();
    logic [CFG_W-1:0] dim_plan [12];
    int unsigned      d;
    dim_plan = '{4'd8, 4'd3, 4'd15, 4'd5, 4'd1, 4'd6, 4'd0, 4'd2, 4'd7, 4'd4, 4'd12, 4'd8};
    foreach (dim_plan[p]) begin
      write_dim(dim_plan[p]);
      d       = effective_dim(dim_plan[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (d) send_coord(random_coord());
      // Now and then a point is left unfinished so that the next setting takes over mid-point.
      if (d > 1 && $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, d - 1)) send_coord(random_coord());
      no_gaps = 1'b0;
    end
  endtask

  initial begin : term_ready_drive
    int unsigned stall_left;
    int unsigned r;
    stall_left    = 0;
    term_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        term_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (no_gaps) begin
        term_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        term_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          term_ch.ready <= 1'b1;
        end else begin
          term_ch.ready <= 1'b0;
          stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk_i) begin : term_check
    term_item_t got;
    term_item_t want;
    if (rst_ni && term_ch.valid && term_ch.ready) begin
      got = term_ch.data;
      if (expected_terms.size() == 0) begin
        report_mismatch("unexpected entry", got.term_index, got.term_value, '0);
      end else begin
        want = expected_terms.pop_front();
        if (got.term_value !== want.term_value)
          report_mismatch("term_value", want.term_index, got.term_value, want.term_value);
        if (got.term_index !== want.term_index)
          report_mismatch("term_index", want.term_index, got.term_index, want.term_index);
        if (got.row_end !== want.row_end)
          report_mismatch("row_end", want.term_index, got.row_end, want.row_end);
        terms_checked++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (coord_ch.valid && coord_ch.ready) || (term_ch.valid && term_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d entries outstanding",
               STALL_LIMIT, expected_terms.size());
      $display("quadratic_basis_expansion regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    coord_ch.valid = 1'b0;
    coord_ch.data  = '0;
    dim_reg        = ACTIVE_DIM_RST;
    point_fill     = 0;
    foreach (point_store[k]) point_store[k] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_corner_point();
    test_dim_bounds();
    test_midpoint_dim_change();
    test_backpressure();
    test_random_points();
    drain_results();

    $display("Covered %0d coordinates, %0d rows and %0d checked entries over %0d settings",
             coords_sent, rows_predicted, terms_checked, dim_writes);
    $display("of the dimension, with out-of-range and mid-point changes and a long output stall.");
    if (err_count == 0) begin
      $display("quadratic_basis_expansion regression: pass");
    end else begin
      $display("quadratic_basis_expansion regression: fail");
    end
    $finish;
  end

endmodule
